// ----- rtl/bpc_pkg.sv -----
// Shared types and constants of the button press classifier.
// No dependencies; used by every module of the block but bpc_checker.
package bpc_pkg;

  localparam int TIMER_WIDTH_DEF = 16;
  localparam int PERIOD_W        = 16;
  localparam int SINCE_W         = 16;
  localparam int CFG_DATA_W      = 16;
  localparam int CFG_IDX_W       = 2;

  localparam logic [PERIOD_W-1:0] DEF_DEBOUNCE = 16'd20;
  localparam logic [PERIOD_W-1:0] DEF_LONG     = 16'd1000;
  localparam logic [PERIOD_W-1:0] DEF_WINDOW   = 16'd300;
  localparam logic [SINCE_W-1:0]  SINCE_MAX    = {SINCE_W{1'b1}};
  localparam logic [1:0]          SECOND_CLICK = 2'd2;
  localparam logic [1:0]          FIRST_CLICK  = 2'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACTIVE_HIGH  = 2'd0,
    CFG_DEBOUNCE     = 2'd1,
    CFG_LONG_PRESS   = 2'd2,
    CFG_DOUBLE_CLICK = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_PRESS  = 3'd1,
    PH_SHORT  = 3'd2,
    PH_LONG   = 3'd3,
    PH_DOUBLE = 3'd4
  } phase_t;

  // Settings seen by the step logic, apart from the timer load values.
  typedef struct packed {
    logic                active_high;
    logic [PERIOD_W-1:0] dper;
  } bpc_cfg_t;

  // Fixed-width part of the classifier state.
  typedef struct packed {
    logic               prev_level;
    logic               deb_run;
    logic               hold_run;
    logic               win_run;
    logic               is_held;
    logic               awaiting;
    logic [1:0]         tally;
    phase_t             phase;
    logic [SINCE_W-1:0] since;
  } bpc_state_t;

  typedef struct packed {
    logic   ev_pressed;
    logic   ev_released;
    logic   ev_double_click;
    logic   ev_long_press;
    phase_t button_phase;
    logic   held;
  } bpc_result_t;

endpackage

// ----- rtl/bpc_cfg_regs.sv -----
// Configuration registers of the button press classifier and the derived
// effective periods and timer load values. Depends on bpc_pkg.
module bpc_cfg_regs #(
  parameter int TIMER_WIDTH = bpc_pkg::TIMER_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [bpc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bpc_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  output bpc_pkg::bpc_cfg_t                   cfg_o,
  output logic [TIMER_WIDTH-1:0]              deb_load_o,
  output logic [TIMER_WIDTH-1:0]              hold_load_o,
  output logic [TIMER_WIDTH-1:0]              win_load_o
);
  import bpc_pkg::*;

  localparam logic [63:0] TMR_MAX = (64'd1 << TIMER_WIDTH) - 64'd1;

  logic                active_high_r;
  logic [PERIOD_W-1:0] deb_ticks_r;
  logic [PERIOD_W-1:0] long_ticks_r;
  logic [PERIOD_W-1:0] win_ticks_r;
  logic [PERIOD_W-1:0] long_per;
  logic [PERIOD_W-1:0] win_per;

  // Saturate a period to the largest count the timers can hold.
  function automatic logic [TIMER_WIDTH-1:0] sat_load(input logic [PERIOD_W-1:0] per);
    logic [63:0] p64;
    p64 = 64'(per);
    return (p64 > TMR_MAX) ? TMR_MAX[TIMER_WIDTH-1:0] : p64[TIMER_WIDTH-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_high_r <= 1'b0;
      deb_ticks_r   <= DEF_DEBOUNCE;
      long_ticks_r  <= DEF_LONG;
      win_ticks_r   <= DEF_WINDOW;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ACTIVE_HIGH:  active_high_r <= cfg_wdata[0];
        CFG_DEBOUNCE:     deb_ticks_r   <= cfg_wdata[PERIOD_W-1:0];
        CFG_LONG_PRESS:   long_ticks_r  <= cfg_wdata[PERIOD_W-1:0];
        CFG_DOUBLE_CLICK: win_ticks_r   <= cfg_wdata[PERIOD_W-1:0];
      endcase
    end
  end

  // A zero register selects the default period.
  assign cfg_o.active_high = active_high_r;
  assign cfg_o.dper        = (deb_ticks_r == '0) ? DEF_DEBOUNCE : deb_ticks_r;
  assign long_per          = (long_ticks_r == '0) ? DEF_LONG : long_ticks_r;
  assign win_per           = (win_ticks_r == '0) ? DEF_WINDOW : win_ticks_r;

  assign deb_load_o  = sat_load(cfg_o.dper);
  assign hold_load_o = sat_load(long_per);
  assign win_load_o  = sat_load(win_per);

endmodule

// ----- rtl/bpc_step.sv -----
// Next-state and result logic for one tick of the button press classifier.
// Purely combinational. Depends on bpc_pkg.
module bpc_step #(
  parameter int TIMER_WIDTH = bpc_pkg::TIMER_WIDTH_DEF
) (
  input  logic                   pin_level,
  input  bpc_pkg::bpc_cfg_t      cfg_i,
  input  logic [TIMER_WIDTH-1:0] deb_load_i,
  input  logic [TIMER_WIDTH-1:0] hold_load_i,
  input  logic [TIMER_WIDTH-1:0] win_load_i,
  input  bpc_pkg::bpc_state_t    st_i,
  input  logic [TIMER_WIDTH-1:0] deb_left_i,
  input  logic [TIMER_WIDTH-1:0] hold_left_i,
  input  logic [TIMER_WIDTH-1:0] win_left_i,
  output bpc_pkg::bpc_state_t    st_o,
  output logic [TIMER_WIDTH-1:0] deb_left_o,
  output logic [TIMER_WIDTH-1:0] hold_left_o,
  output logic [TIMER_WIDTH-1:0] win_left_o,
  output bpc_pkg::bpc_result_t   res_o
);
  import bpc_pkg::*;

  always_comb begin
    logic       change;
    logic       active;
    bpc_state_t s;
    logic [TIMER_WIDTH-1:0] d, h, w;
    logic evp, evr, evd, evl;

    s      = st_i;
    change = (pin_level != st_i.prev_level);
    active = cfg_i.active_high ? pin_level : ~pin_level;
    evp    = 1'b0;
    evr    = 1'b0;
    evd    = 1'b0;
    evl    = 1'b0;
    s.prev_level = pin_level;

    if (s.since != SINCE_MAX) s.since = s.since + 1'b1;

    d = (s.deb_run  && deb_left_i  != '0) ? deb_left_i  - 1'b1 : deb_left_i;
    h = (s.hold_run && hold_left_i != '0) ? hold_left_i - 1'b1 : hold_left_i;
    w = (s.win_run  && win_left_i  != '0) ? win_left_i  - 1'b1 : win_left_i;

    // Debounce expiry; a level change on this tick restarts the timer instead.
    if (change) begin
      d         = deb_load_i;
      s.deb_run = 1'b1;
    end else if (s.deb_run && d == '0) begin
      s.deb_run = 1'b0;
      if (s.phase == PH_LONG && !s.is_held) s.phase = PH_IDLE;
      // Events too close together are ignored.
      if (!((s.since < (cfg_i.dper >> 1)) && (active != s.is_held))) begin
        if (active && !s.is_held) begin
          s.is_held = 1'b1;
          if (s.awaiting) begin
            s.win_run  = 1'b0;
            s.awaiting = 1'b0;
            s.tally    = SECOND_CLICK;
          end else begin
            s.tally = FIRST_CLICK;
          end
          s.phase    = PH_PRESS;
          h          = hold_load_i;
          s.hold_run = 1'b1;
          evp        = 1'b1;
          s.since    = '0;
        end else if (!active && s.is_held) begin
          s.is_held  = 1'b0;
          s.hold_run = 1'b0;
          if (s.phase == PH_PRESS) s.phase = PH_SHORT;
          evr = 1'b1;
          if (s.tally == SECOND_CLICK && s.phase != PH_LONG) begin
            s.phase = PH_DOUBLE;
            evd     = 1'b1;
            s.tally = 2'd0;
          end else if (s.tally == FIRST_CLICK && s.phase != PH_LONG) begin
            s.awaiting = 1'b1;
            s.phase    = PH_IDLE;
            w          = win_load_i;
            s.win_run  = 1'b1;
          end
          s.since = '0;
        end
      end
    end

    // Long press expiry.
    if (s.hold_run && h == '0) begin
      s.hold_run = 1'b0;
      if (s.is_held) begin
        if (active) begin
          s.awaiting = 1'b0;
          s.win_run  = 1'b0;
          s.tally    = 2'd0;
          s.phase    = PH_LONG;
          evl        = 1'b1;
        end else begin
          s.is_held = 1'b0;
        end
      end
    end

    // Double-click window expiry.
    if (s.win_run && w == '0) begin
      s.win_run = 1'b0;
      if (s.awaiting) begin
        s.awaiting = 1'b0;
        if (!s.is_held) s.phase = PH_IDLE;
        s.tally = 2'd0;
      end
    end

    st_o        = s;
    deb_left_o  = d;
    hold_left_o = h;
    win_left_o  = w;
    res_o.ev_pressed      = evp;
    res_o.ev_released     = evr;
    res_o.ev_double_click = evd;
    res_o.ev_long_press   = evl;
    res_o.button_phase    = s.phase;
    res_o.held            = s.is_held;
  end

endmodule

// ----- rtl/button_press_classifier_core.sv -----
// Top level of the button press classifier: state registers, result
// register and handshakes. Depends on bpc_pkg, bpc_cfg_regs and bpc_step.
//
// Usage: each input request is one millisecond tick carrying the raw pin
// level on in_pin_level. For every accepted request the block returns one
// result request with the four event flags, the button phase and the
// debounced held flag. Requests move on valid/ready: a request is taken at
// a rising edge with valid and ready both high.
//
// The result of a tick is in the output register in the cycle after the tick
// is accepted. The block takes one tick per cycle while the receiver takes
// its results; the whole tick update is a single pass of short logic between
// the state registers and the result register.
//
// While the receiver stalls, the held result stays on the outputs and
// in_ready is low, so no tick is lost. in_ready returns high in the cycle
// the receiver takes the result, so back-to-back ticks flow without gaps.
//
// Reset (rst_n low, synchronous) loads the register defaults, restarts the
// debounce timer with its full period, sets the previous level to the
// inactive level and empties the result register. Configuration writes on
// cfg_we/cfg_index/cfg_wdata reach each timer at its next load.
module button_press_classifier_core #(
  parameter int TIMER_WIDTH = bpc_pkg::TIMER_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [bpc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bpc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_pin_level,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_ev_pressed,
  output logic                           out_ev_released,
  output logic                           out_ev_double_click,
  output logic                           out_ev_long_press,
  output logic [2:0]                     out_button_phase,
  output logic                           out_held
);
  import bpc_pkg::*;

  // The reset load is the default debounce period cut to TIMER_WIDTH bits.
  localparam logic [TIMER_WIDTH-1:0] DEB_RESET = TIMER_WIDTH'(DEF_DEBOUNCE);

  bpc_cfg_t               cfg;
  logic [TIMER_WIDTH-1:0] deb_load, hold_load, win_load;

  bpc_state_t             st_r, st_nxt;
  logic [TIMER_WIDTH-1:0] deb_left_r, deb_left_nxt;
  logic [TIMER_WIDTH-1:0] hold_left_r, hold_left_nxt;
  logic [TIMER_WIDTH-1:0] win_left_r, win_left_nxt;
  bpc_result_t            res_r, res_nxt;
  logic                   out_valid_r;
  logic                   in_fire;

  bpc_cfg_regs #(.TIMER_WIDTH(TIMER_WIDTH)) u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .cfg_o       (cfg),
    .deb_load_o  (deb_load),
    .hold_load_o (hold_load),
    .win_load_o  (win_load)
  );

  bpc_step #(.TIMER_WIDTH(TIMER_WIDTH)) u_step (
    .pin_level   (in_pin_level),
    .cfg_i       (cfg),
    .deb_load_i  (deb_load),
    .hold_load_i (hold_load),
    .win_load_i  (win_load),
    .st_i        (st_r),
    .deb_left_i  (deb_left_r),
    .hold_left_i (hold_left_r),
    .win_left_i  (win_left_r),
    .st_o        (st_nxt),
    .deb_left_o  (deb_left_nxt),
    .hold_left_o (hold_left_nxt),
    .win_left_o  (win_left_nxt),
    .res_o       (res_nxt)
  );

  // The result register frees up in the same cycle the receiver takes it.
  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.prev_level <= 1'b1;   // inactive level, since active_high resets to 0
      st_r.deb_run    <= 1'b1;
      st_r.hold_run   <= 1'b0;
      st_r.win_run    <= 1'b0;
      st_r.is_held    <= 1'b0;
      st_r.awaiting   <= 1'b0;
      st_r.tally      <= 2'd0;
      st_r.phase      <= PH_IDLE;
      st_r.since      <= '0;
      deb_left_r      <= DEB_RESET;
      hold_left_r     <= '0;
      win_left_r      <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      if (in_fire) begin
        st_r        <= st_nxt;
        deb_left_r  <= deb_left_nxt;
        hold_left_r <= hold_left_nxt;
        win_left_r  <= win_left_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload; it only loads together with a new tick.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_ev_pressed      = res_r.ev_pressed;
  assign out_ev_released     = res_r.ev_released;
  assign out_ev_double_click = res_r.ev_double_click;
  assign out_ev_long_press   = res_r.ev_long_press;
  assign out_button_phase    = res_r.button_phase;
  assign out_held            = res_r.held;

endmodule

// ----- rtl/bpc_checker.sv -----
// Port-level checker for the button press classifier, bound to the top.
// Depends on button_press_classifier_core.
module bpc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_ev_pressed,
  input logic       out_ev_released,
  input logic       out_ev_double_click,
  input logic       out_held
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // An accepted tick always shows up as a result in the next cycle.
  a_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted tick produced no result");

  // With no result pending, the block must take a tick.
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  // Event flags agree with the held flag they leave behind.
  a_events: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_ev_pressed || out_held) &&
                  (!out_ev_released || (!out_held && !out_ev_pressed)) &&
                  (!out_ev_double_click || out_ev_released))
    else $error("event flags inconsistent with held flag");

endmodule

bind button_press_classifier_core bpc_checker u_bpc_checker (.*);

// ----- sim/bpc_event_checker.sv -----
// Checker for the button press classifier: predicts every tick result and compares it.
// Depends on bpc_pkg. It only watches the ports of the block and never drives them.
module bpc_event_checker
  import bpc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic                  in_pin_level,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic                  out_ev_pressed,
  input  logic                  out_ev_released,
  input  logic                  out_ev_double_click,
  input  logic                  out_ev_long_press,
  input  logic [2:0]            out_button_phase,
  input  logic                  out_held,
  output int                    fail_count,
  output int                    pending,
  output int                    results_checked,
  output int                    double_clicks,
  output int                    long_presses
);

  // Shadow copy of the registers.
  logic                act_high_q;
  logic [PERIOD_W-1:0] deb_reg_q, long_reg_q, win_reg_q;

  // Shadow copy of the classifier state. With 16-bit timers a 16-bit period
  // always fits, so loads never saturate.
  logic                lvl_prev;
  logic [PERIOD_W-1:0] deb_left, hold_left, win_left;
  logic                deb_run, hold_run, win_run;
  logic                held_q, awaiting_q;
  logic [1:0]          tally_q;
  phase_t              phase_q;
  logic [SINCE_W-1:0]  since_q;

  bpc_result_t expected_events[$];
  int          errors, checked, doubles, longs;

  function automatic logic [PERIOD_W-1:0] period_or(input logic [PERIOD_W-1:0] r,
                                                    input logic [PERIOD_W-1:0] dflt);
    return (r != '0) ? r : dflt;
  endfunction

  // Advances the shadow state by one tick and returns the result it causes.
  function automatic bpc_result_t classify_tick(input logic pin);
    bpc_result_t         r;
    logic                change, active;
    logic [PERIOD_W-1:0] dper;
    r      = '0;
    change = (pin != lvl_prev);
    active = act_high_q ? pin : ~pin;
    dper   = period_or(deb_reg_q, DEF_DEBOUNCE);
    lvl_prev = pin;
    if (since_q != SINCE_MAX) since_q++;

    // Timers loaded further down on this tick keep their full period.
    if (deb_run && deb_left != '0) deb_left--;
    if (hold_run && hold_left != '0) hold_left--;
    if (win_run && win_left != '0) win_left--;

    if (change) begin
      // A level change restarts debouncing, even on the tick it would expire.
      deb_left = dper;
      deb_run  = 1'b1;
    end else if (deb_run && deb_left == '0) begin
      deb_run = 1'b0;
      if (phase_q == PH_LONG && !held_q) phase_q = PH_IDLE;
      // Too soon after the last event a new level is ignored.
      if (!(since_q < (dper >> 1) && active != held_q)) begin
        if (active && !held_q) begin
          held_q = 1'b1;
          if (awaiting_q) begin
            win_run    = 1'b0;
            awaiting_q = 1'b0;
            tally_q    = SECOND_CLICK;
          end else begin
            tally_q = FIRST_CLICK;
          end
          phase_q      = PH_PRESS;
          hold_left    = period_or(long_reg_q, DEF_LONG);
          hold_run     = 1'b1;
          r.ev_pressed = 1'b1;
          since_q      = '0;
        end else if (!active && held_q) begin
          held_q   = 1'b0;
          hold_run = 1'b0;
          if (phase_q == PH_PRESS) phase_q = PH_SHORT;
          r.ev_released = 1'b1;
          if (tally_q == SECOND_CLICK && phase_q != PH_LONG) begin
            phase_q           = PH_DOUBLE;
            r.ev_double_click = 1'b1;
            tally_q           = 2'd0;
          end else if (tally_q == FIRST_CLICK && phase_q != PH_LONG) begin
            awaiting_q = 1'b1;
            phase_q    = PH_IDLE;
            win_left   = period_or(win_reg_q, DEF_WINDOW);
            win_run    = 1'b1;
          end
          since_q = '0;
        end
      end
    end

    if (hold_run && hold_left == '0) begin
      hold_run = 1'b0;
      if (held_q) begin
        if (active) begin
          awaiting_q      = 1'b0;
          win_run         = 1'b0;
          tally_q         = 2'd0;
          phase_q         = PH_LONG;
          r.ev_long_press = 1'b1;
        end else begin
          // Released but not yet debounced: the hold silently ends.
          held_q = 1'b0;
        end
      end
    end

    if (win_run && win_left == '0) begin
      win_run = 1'b0;
      if (awaiting_q) begin
        awaiting_q = 1'b0;
        if (!held_q) phase_q = PH_IDLE;
        tally_q = 2'd0;
      end
    end

    r.button_phase = phase_q;
    r.held         = held_q;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    bpc_result_t want;
    logic        bad;
    if (!rst_n) begin
      act_high_q = 1'b0;
      deb_reg_q  = DEF_DEBOUNCE;
      long_reg_q = DEF_LONG;
      win_reg_q  = DEF_WINDOW;
      lvl_prev   = 1'b1;
      deb_left   = DEF_DEBOUNCE;
      deb_run    = 1'b1;
      hold_left  = '0;
      hold_run   = 1'b0;
      win_left   = '0;
      win_run    = 1'b0;
      held_q     = 1'b0;
      awaiting_q = 1'b0;
      tally_q    = 2'd0;
      phase_q    = PH_IDLE;
      since_q    = '0;
      expected_events.delete();
    end else begin
      // A result leaves through the result register after its tick is taken, so compare before predicting.
      if (out_valid && out_ready) begin
        checked++;
        if (out_ev_double_click) doubles++;
        if (out_ev_long_press) longs++;
        if (expected_events.size() == 0) begin
          if (errors < 10) $display("[%0t] result with no tick waiting", $time);
          errors++;
        end else begin
          want = expected_events.pop_front();
          bad  = (out_ev_pressed !== want.ev_pressed) ||
                 (out_ev_released !== want.ev_released) ||
                 (out_ev_double_click !== want.ev_double_click) ||
                 (out_ev_long_press !== want.ev_long_press) ||
                 (out_button_phase !== want.button_phase) ||
                 (out_held !== want.held);
          if (bad) begin
            if (errors < 10) begin
              $display("[%0t] result %0d: want pr%b rl%b dc%b lp%b phase %0d held %b",
                       $time, checked, want.ev_pressed, want.ev_released,
                       want.ev_double_click, want.ev_long_press,
                       want.button_phase, want.held);
              $display("[%0t] result %0d: got  pr%b rl%b dc%b lp%b phase %0d held %b",
                       $time, checked, out_ev_pressed, out_ev_released,
                       out_ev_double_click, out_ev_long_press,
                       out_button_phase, out_held);
            end
            errors++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_ACTIVE_HIGH:  act_high_q = cfg_wdata[0];
          CFG_DEBOUNCE:     deb_reg_q  = cfg_wdata;
          CFG_LONG_PRESS:   long_reg_q = cfg_wdata;
          CFG_DOUBLE_CLICK: win_reg_q  = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && in_ready) expected_events.push_back(classify_tick(in_pin_level));
    end
    fail_count      <= errors;
    pending         <= expected_events.size();
    results_checked <= checked;
    double_clicks   <= doubles;
    long_presses    <= longs;
  end

endmodule

// ----- sim/button_press_classifier_core_tb.sv -----
// Testbench top of the button press classifier: clock, reset, tick and register stimulus.
// Depends on bpc_pkg, button_press_classifier_core and bpc_event_checker.
module button_press_classifier_core_tb;
  import bpc_pkg::*;

  // Rough number of tick requests for the whole run.
  localparam int TICK_TARGET = 1250;
  // Length of each long receiver hold-off, in cycles.
  localparam int LONG_STALL  = 300;
  // No generated level run is longer than this many ticks.
  localparam int RUN_CAP     = 60;

  // Hand-written opening sequence, leftmost bit first, with active-low pins,
  // debounce 2, long press 4 and double-click window 6. It walks through a
  // press, a short release that opens the window, a second click completing a
  // double click, a hold that reaches a long press, the release out of the
  // long press phase, and a level change landing on a debounce expiry tick.
  localparam logic [0:24] DIRECTED_PINS = 25'b0001110001110000000111001;

  logic                  clk          = 1'b0;
  logic                  rst_n        = 1'b0;
  logic                  cfg_we       = 1'b0;
  cfg_idx_t              cfg_index    = CFG_ACTIVE_HIGH;
  logic [CFG_DATA_W-1:0] cfg_wdata    = '0;
  logic                  in_valid     = 1'b0;
  logic                  in_ready;
  logic                  in_pin_level = 1'b1;
  logic                  out_valid;
  logic                  out_ready    = 1'b0;
  logic                  out_ev_pressed;
  logic                  out_ev_released;
  logic                  out_ev_double_click;
  logic                  out_ev_long_press;
  logic [2:0]            out_button_phase;
  logic                  out_held;

  int fail_count, pending, results_checked, double_clicks, long_presses;
  int ticks_sent, settings_used, stall_requests, stall_served;
  int send_idle_pct, recv_idle_pct;
  // Debounce and hold periods as seen by the run-length generator.
  int deb_gen  = 20;
  int long_gen = 50;

  button_press_classifier_core dut (.*);

  bpc_event_checker checker_i (.*);

  initial begin
    forever #2 clk = ~clk;
  end

  // Guard against a hung handshake. The slowest correct run stays far below.
  initial begin
    #800_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Result side. It drops ready at random per cycle, and once per request
  // from the stimulus it holds ready low for a long stretch so that the
  // output register fills and the block has to stall its input.
  initial begin
    forever begin
      @(posedge clk);
      if (stall_served != stall_requests) begin
        stall_served = stall_requests;
        out_ready <= 1'b0;
        repeat (LONG_STALL) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Offers one tick request, after a random number of idle cycles, and
  // returns at the edge where it is taken. Valid stays high between
  // back-to-back requests.
  task automatic send_tick(input logic lvl);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_pin_level <= lvl;
    do @(posedge clk); while (!in_ready);
    ticks_sent++;
  endtask

  // Stops offering ticks and waits until every result has been taken. The
  // first edge is always skipped so the checker has seen the last request.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Writes one register and keeps the run-length generator in step with the
  // new periods. A zero period means the default of the block.
  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    int eff;
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    eff = int'(val);
    case (idx)
      CFG_DEBOUNCE: begin
        if (eff == 0) eff = int'(DEF_DEBOUNCE);
        deb_gen = (eff > 30) ? 30 : eff;
      end
      CFG_LONG_PRESS: begin
        if (eff == 0) eff = int'(DEF_LONG);
        long_gen = (eff > 50) ? 50 : eff;
      end
      default: ;
    endcase
  endtask

  // Mostly short periods so that events come often, with zero (the default)
  // and the largest value mixed in.
  function automatic logic [CFG_DATA_W-1:0] pick_period(input int hi);
    int roll = $urandom_range(99);
    if (roll < 8) return '0;
    if (roll < 12) return '1;
    return CFG_DATA_W'($urandom_range(hi, 1));
  endfunction

  // Plays a number of level runs. Most runs are clean presses or releases
  // held past the debounce time, sometimes long enough for a long press; the
  // rest are bounces shorter than the debounce time and random noise.
  task automatic play_runs(input int n_runs);
    logic lvl;
    int   len, kind;
    lvl = in_pin_level;
    repeat (n_runs) begin
      if (ticks_sent >= TICK_TARGET) break;
      lvl  = ~lvl;
      kind = $urandom_range(9);
      if (kind < 7) len = deb_gen + $urandom_range(long_gen + 4, 0);
      else len = $urandom_range(deb_gen, 1);
      if (len > RUN_CAP) len = RUN_CAP;
      if (kind == 9) begin
        repeat (len) send_tick(1'($urandom_range(1)));
        lvl = in_pin_level;
      end else begin
        repeat (len) send_tick(lvl);
      end
    end
  endtask

  initial begin : stimulus
    int phase_no;
    send_idle_pct = 8;
    recv_idle_pct = 85;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed opening. The upper bits of the polarity write must be ignored.
    write_reg(CFG_ACTIVE_HIGH, 16'hFFFE);
    write_reg(CFG_DEBOUNCE, 16'd2);
    write_reg(CFG_LONG_PRESS, 16'd4);
    write_reg(CFG_DOUBLE_CLICK, 16'd6);
    settings_used = 1;
    for (int i = 0; i < 25; i++) send_tick(DIRECTED_PINS[i]);

    // Random phases. Registers only change once the block has delivered
    // every result; the timers may still be running, which is how a new
    // period meets a timer loaded under the old one.
    phase_no = 0;
    while (ticks_sent < TICK_TARGET) begin
      settle();
      if (ticks_sent >= 2 * TICK_TARGET / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (ticks_sent >= TICK_TARGET / 3) begin
        send_idle_pct = 85;
        recv_idle_pct = 8;
      end
      if (phase_no == 1) begin
        // Largest values everywhere, active-high pins.
        write_reg(CFG_ACTIVE_HIGH, '1);
        write_reg(CFG_DEBOUNCE, '1);
        write_reg(CFG_LONG_PRESS, '1);
        write_reg(CFG_DOUBLE_CLICK, '1);
      end else if (phase_no == 2) begin
        // Zero everywhere, so the defaults of the block take over.
        write_reg(CFG_ACTIVE_HIGH, '0);
        write_reg(CFG_DEBOUNCE, '0);
        write_reg(CFG_LONG_PRESS, '0);
        write_reg(CFG_DOUBLE_CLICK, '0);
      end else begin
        if ($urandom_range(1)) write_reg(CFG_ACTIVE_HIGH, CFG_DATA_W'($urandom()));
        if ($urandom_range(1)) write_reg(CFG_DEBOUNCE, pick_period(8));
        if ($urandom_range(1)) write_reg(CFG_LONG_PRESS, pick_period(40));
        if ($urandom_range(1)) write_reg(CFG_DOUBLE_CLICK, pick_period(40));
      end
      settings_used++;
      // Now and then the receiver blocks for a long time while ticks keep coming.
      if (phase_no % 8 == 1) stall_requests++;
      play_runs($urandom_range(8, 2));
      phase_no++;
    end

    settle();
    repeat (10) @(posedge clk);
    $display("Covered %0d ticks under %0d register settings, %0d results compared.",
             ticks_sent, settings_used, results_checked);
    $display("Saw %0d long presses and %0d double clicks, %0d mismatching results.",
             long_presses, double_clicks, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
